### rtl/core/btc_pkg.sv
package btc_pkg;

    localparam int MAX_BLOCK = 16;
    localparam int KEY_SLOTS = 16;
    localparam int BLK_CAP   = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;
    localparam int POS_W     = $clog2(KEY_SLOTS);
    localparam int LEN_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int KEY_W     = KEY_SLOTS * POS_W;
    localparam int CFG_IDX_W = 8;
    localparam int NBANK     = 2;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h78;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERM_KEY  = 8'd1;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CHAR_W-1:0] t_char;

    // front to queue: byte write and block hand-off
    typedef struct packed {
        logic  we;
        logic  bank;
        t_pos  addr;
        t_char data;
        logic  push;
        t_len  cnt;
        logic  last;
    } t_front_req;

    // back to queue: read address and block release
    typedef struct packed {
        logic done;
        logic bank;
        t_pos addr;
    } t_back_req;

    function automatic t_len eff_len(input t_len len_raw);
        t_len len;
        len = len_raw;
        if (len_raw == '0) begin
            len = t_len'(1);
        end else if (len_raw > t_len'(BLK_CAP)) begin
            len = t_len'(BLK_CAP);
        end
        return len;
    endfunction

endpackage

### rtl/core/btc_front.sv
module btc_front
    import btc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_char             i_char_in,
    input  logic              i_msg_end,
    input  t_len              i_len,
    input  logic              i_clr,
    input  logic [NBANK-1:0]  i_busy,
    output logic              o_full,
    output t_front_req        o_req
);

    t_len r_fill, n_fill;
    logic r_wbank, n_wbank;
    logic accept;
    logic keep;
    t_len fill_inc;

    assign o_full   = i_busy[r_wbank];
    assign accept   = i_push && !o_full;
    assign keep     = (i_char_in != SPACE_CHAR);
    assign fill_inc = r_fill + t_len'(1);

    always_comb begin
        o_req      = '0;
        o_req.bank = r_wbank;
        o_req.addr = r_fill[POS_W-1:0];
        o_req.data = i_char_in;
        n_fill     = r_fill;
        n_wbank    = r_wbank;
        if (accept) begin
            if (keep) begin
                o_req.we = 1'b1;
                n_fill   = fill_inc;
                if (fill_inc >= i_len || i_msg_end) begin
                    o_req.push = 1'b1;
                    o_req.cnt  = fill_inc;
                    o_req.last = i_msg_end;
                end
            end else if (i_msg_end && r_fill != '0) begin
                o_req.push = 1'b1;
                o_req.cnt  = r_fill;
                o_req.last = 1'b1;
            end
            if (o_req.push) begin
                n_fill  = '0;
                n_wbank = !r_wbank;
            end
        end
        if (i_clr) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_wbank <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_wbank <= n_wbank;
        end
    end

endmodule

### rtl/core/btc_blkq.sv
module btc_blkq
    import btc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_front_req        i_freq,
    input  t_back_req         i_breq,
    output logic [NBANK-1:0]  o_busy,
    output t_char             o_rd_char,
    output t_len              o_desc_cnt,
    output logic              o_desc_last
);

    t_char r_buf [NBANK][KEY_SLOTS];
    t_len  r_cnt [NBANK];
    logic  r_last [NBANK];
    logic [NBANK-1:0] r_busy, n_busy;

    assign o_busy      = r_busy;
    assign o_rd_char   = r_buf[i_breq.bank][i_breq.addr];
    assign o_desc_cnt  = r_cnt[i_breq.bank];
    assign o_desc_last = r_last[i_breq.bank];

    always_comb begin
        n_busy = r_busy;
        if (i_freq.push) begin
            n_busy[i_freq.bank] = 1'b1;
        end
        if (i_breq.done) begin
            n_busy[i_breq.bank] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_freq.we) begin
            r_buf[i_freq.bank][i_freq.addr] <= i_freq.data;
        end
        if (i_freq.push) begin
            r_cnt[i_freq.bank]  <= i_freq.cnt;
            r_last[i_freq.bank] <= i_freq.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_freq.push |-> !r_busy[i_freq.bank])
        else $error("block handed to a bank still in use");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_breq.done |-> r_busy[i_breq.bank])
        else $error("release of a bank that holds no block");

endmodule

### rtl/core/btc_back.sv
module btc_back
    import btc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NBANK-1:0]  i_busy,
    input  t_char             i_rd_char,
    input  t_len              i_desc_cnt,
    input  logic              i_desc_last,
    input  t_len              i_len,
    input  logic [KEY_W-1:0]  i_perm_key,
    input  logic              i_pop,
    output t_back_req         o_breq,
    output logic              o_empty,
    output t_char             o_char_out,
    output logic              o_block_last,
    output logic              o_msg_last
);

    t_pos  r_pos;
    logic  r_rbank;
    logic  r_out_valid;
    t_char r_out_char;
    logic  r_out_block_last;
    logic  r_out_msg_last;
    t_pos  src;
    logic  step;
    logic  is_end;
    t_char rd_char;

    assign src     = i_perm_key[r_pos*POS_W +: POS_W];
    assign step    = i_busy[r_rbank] && (!r_out_valid || i_pop);
    assign is_end  = ({1'b0, r_pos} == (i_len - t_len'(1)));
    // positions past the real bytes of a flushed block read as padding
    assign rd_char = ({1'b0, src} < i_desc_cnt) ? i_rd_char : PAD_CHAR;

    assign o_breq.done  = step && is_end;
    assign o_breq.bank  = r_rbank;
    assign o_breq.addr  = src;
    assign o_empty      = !r_out_valid;
    assign o_char_out   = r_out_char;
    assign o_block_last = r_out_block_last;
    assign o_msg_last   = r_out_msg_last;

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char       <= rd_char;
            r_out_block_last <= is_end;
            r_out_msg_last   <= is_end && i_desc_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_rbank     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
                if (is_end) begin
                    r_pos   <= '0;
                    r_rbank <= !r_rbank;
                end else begin
                    r_pos <= r_pos + t_pos'(1);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> i_busy[r_rbank])
        else $error("bank released in the middle of a block");

    a_msg_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_msg_last) |-> r_out_block_last)
        else $error("message end flagged off a block boundary");

endmodule

### rtl/core/block_transposition_cipher.sv
// channel   direction  handshake                 payload
// input     in         push / full               i_char_in, i_msg_end
// result    out        empty / pop               o_char_out, o_block_last, o_msg_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one input item per cycle while the current write bank is free
// a block of L bytes leaves one byte per cycle from the output register while pop is held
// two banks let one block fill while the other drains
// full rises when both banks hold blocks awaiting output
// synchronous active-low reset; buffer contents are not cleared
module block_transposition_cipher
    import btc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CHAR_W-1:0]     i_char_in,
    input  logic                  i_msg_end,
    output logic                  empty,
    input  logic                  pop,
    output logic [CHAR_W-1:0]     o_char_out,
    output logic                  o_block_last,
    output logic                  o_msg_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [KEY_W-1:0]      i_cfg_data
);

    t_len             r_block_len;
    logic [KEY_W-1:0] r_perm_key;
    t_len             len;
    logic             len_wr;
    t_front_req       freq;
    t_back_req        breq;
    logic [NBANK-1:0] busy;
    t_char            rd_char;
    t_len             desc_cnt;
    logic             desc_last;

    assign o_cfg_ready = 1'b1;
    assign len_wr      = i_cfg_valid && (i_cfg_index == CFG_BLOCK_LEN);
    assign len         = eff_len(r_block_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= t_len'(16);
            r_perm_key  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data[LEN_W-1:0];
                CFG_PERM_KEY:  r_perm_key  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    btc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_char_in (i_char_in),
        .i_msg_end (i_msg_end),
        .i_len     (len),
        .i_clr     (len_wr),
        .i_busy    (busy),
        .o_full    (full),
        .o_req     (freq)
    );

    btc_blkq u_blkq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_freq      (freq),
        .i_breq      (breq),
        .o_busy      (busy),
        .o_rd_char   (rd_char),
        .o_desc_cnt  (desc_cnt),
        .o_desc_last (desc_last)
    );

    btc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_busy       (busy),
        .i_rd_char    (rd_char),
        .i_desc_cnt   (desc_cnt),
        .i_desc_last  (desc_last),
        .i_len        (len),
        .i_perm_key   (r_perm_key),
        .i_pop        (pop),
        .o_breq       (breq),
        .o_empty      (empty),
        .o_char_out   (o_char_out),
        .o_block_last (o_block_last),
        .o_msg_last   (o_msg_last)
    );

endmodule
